// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int PRI_W        = 16;
  localparam int OCC_W        = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef struct packed {
    logic [PRI_W-1:0]          pri;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]          pri;
    logic                      removed;
    logic                      underflow;
    logic                      overflow;
    logic [OCC_W-1:0]          occupancy;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUT,
    ST_DEL
  } state_t;

endpackage

// File: hdl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Request and result channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] item_value;
  logic [PRI_W-1:0]          entry_priority;

  modport source (output valid, req_type, item_value, entry_priority, input ready);
  modport sink   (input valid, req_type, item_value, entry_priority, output ready);
endinterface

interface spq_res_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [PRI_W-1:0]          out_priority;
  logic                      removed;
  logic                      underflow;
  logic                      overflow;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, out_value, out_priority, removed, underflow, overflow,
                  occupancy, input ready);
  modport sink   (input valid, out_value, out_priority, removed, underflow, overflow,
                  occupancy, output ready);
endinterface

// File: hdl/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module spq_store #(
  parameter int DEPTH = spq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  spq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output spq_pkg::entry_t rd_data
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the queue: circular head pointer, insertion scan from the
// tail and the result register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic            clk,
  input  logic            rst,
  spq_req_if.sink         req,
  spq_res_if.source       res,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output spq_pkg::entry_t wr_data,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  spq_pkg::entry_t rd_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  entry_t        pending, pending_next;
  result_t       result, result_next;
  logic          res_valid, res_valid_next;
  logic          req_fire;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] offset);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign req.ready = (state == ST_IDLE) && (!res_valid || res.ready);
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    pos_next       = pos;
    pending_next   = pending;
    result_next    = result;
    res_valid_next = res_valid && !res.ready;
    wr_en          = 1'b0;
    wr_addr        = phys(head, pos);
    wr_data        = pending;
    rd_en          = 1'b0;
    rd_addr        = phys(head, pos - AW'(1));

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          result_next    = '0;
          res_valid_next = 1'b1;
          if (req.req_type == REQ_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              result_next.overflow  = 1'b1;
              result_next.occupancy = OCC_W'(count);
            end else begin
              count_next            = count + CW'(1);
              result_next.occupancy = OCC_W'(count_next);
              pending_next.value    = req.item_value;
              pending_next.pri      = req.entry_priority;
              pos_next              = count[AW-1:0];
              if (count == '0) begin
                wr_en   = 1'b1;
                wr_addr = head;
                wr_data = pending_next;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = phys(head, count[AW-1:0] - AW'(1));
                state_next = ST_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              result_next.underflow = 1'b1;
            end else begin
              res_valid_next = 1'b0;
              rd_en          = 1'b1;
              rd_addr        = head;
              state_next     = ST_DEL;
            end
          end
        end
      end
      ST_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, pos);
        if (rd_data.pri > pending.pri) begin
          wr_data  = rd_data;
          pos_next = pos - AW'(1);
          if (pos == AW'(1)) begin
            state_next = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head, pos - AW'(1) - AW'(1));
          end
        end else begin
          wr_data    = pending;
          state_next = ST_IDLE;
        end
      end
      ST_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = phys(head, pos);
        wr_data    = pending;
        state_next = ST_IDLE;
      end
      ST_DEL: begin
        count_next            = count - CW'(1);
        head_next             = phys(head, AW'(1));
        result_next           = '0;
        result_next.value     = rd_data.value;
        result_next.pri       = rd_data.pri;
        result_next.removed   = 1'b1;
        result_next.occupancy = OCC_W'(count_next);
        res_valid_next        = 1'b1;
        state_next            = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      pos       <= pos_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pending <= pending_next;
    result  <= result_next;
  end

  assign res.valid        = res_valid;
  assign res.out_value    = result.value;
  assign res.out_priority = result.pri;
  assign res.removed      = result.removed;
  assign res.underflow    = result.underflow;
  assign res.overflow     = result.overflow;
  assign res.occupancy    = result.occupancy;

endmodule

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in service order in a single entry memory.
//
// The request channel carries req_type, item_value and entry_priority. An
// insert places the entry behind every entry of lower or equal priority
// number; a delete returns the head entry. Each request gives exactly one
// transfer on the result channel, with flags for removal, underflow and a
// dropped insert, and the occupancy after the request.
//
// The entries sit in a circular buffer addressed from a head pointer, so a
// delete issues one memory read in ST_IDLE and forms the result in ST_DEL,
// or is answered in ST_IDLE alone when the queue is empty. An insert scans
// from the tail, moving one larger entry up by one slot per cycle through
// the single read and write port: it stays in ST_CMP while it passes entries
// and goes to ST_PUT if it reaches the head; it is done in ST_IDLE alone when
// the queue is empty or full. The result of an insert or of a delete on an
// empty queue appears in the cycle after its transfer; that of any other delete is set in ST_DEL.
//
// Reset empties the queue at once; the memory is not cleared. While a
// result is stalled by the receiver no new request is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_res_if.source res
);
  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [spq_pkg::VALUE_W-1:0] out_value,
  input logic [spq_pkg::PRI_W-1:0]          out_priority,
  input logic                               removed,
  input logic                               underflow,
  input logic                               overflow,
  input logic [spq_pkg::OCC_W-1:0]          occupancy
);
  import spq_pkg::*;

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({removed, underflow, overflow}))
    else $error("more than one result flag set");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && underflow) |-> (occupancy == '0 && out_value == '0 && out_priority == '0))
    else $error("underflow reported with a non-empty queue or payload");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && overflow) |-> (occupancy == OCC_W'(CAPACITY)))
    else $error("overflow reported while the queue is not full");

  a_insert_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !removed) |-> (out_value == '0 && out_priority == '0))
    else $error("entry payload shown without a removal");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(out_value) && $stable(out_priority) && $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .out_value    (res.out_value),
  .out_priority (res.out_priority),
  .removed      (res.removed),
  .underflow    (res.underflow),
  .overflow     (res.overflow),
  .occupancy    (res.occupancy)
);
